>>> rtl/core/multichannel_length_prefixed_deframer_defines.svh
// Assertion macros used by the deframer checker.
`ifndef MULTICHANNEL_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define MULTICHANNEL_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define MLPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("deframer check failed");

// next-cycle implication
`define MLPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("deframer check failed");

`endif

>>> rtl/core/mlpd_pkg.sv
// Types and constants of the multichannel length-prefixed deframer.
`default_nettype none
package mlpd_pkg;

	localparam int unsigned CH_W   = 6;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned PH_W   = 3;
	localparam int unsigned ST_W   = 3;

	localparam logic [PH_W-1:0] PH_TYPE  = 3'd0;
	localparam logic [PH_W-1:0] PH_LEN1  = 3'd1;
	localparam logic [PH_W-1:0] PH_LENHI = 3'd2;
	localparam logic [PH_W-1:0] PH_LENLO = 3'd3;
	localparam logic [PH_W-1:0] PH_CODE  = 3'd4;
	localparam logic [PH_W-1:0] PH_BODY  = 3'd5;
	localparam logic [PH_W-1:0] PH_ERR   = 3'd6;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_BADTYPE = 3'd1;
	localparam logic [ST_W-1:0] ST_SHORT   = 3'd2;
	localparam logic [ST_W-1:0] ST_LONG    = 3'd3;
	localparam logic [ST_W-1:0] ST_DISC    = 3'd4;

	localparam logic [BYTE_W-1:0] TYPE_C1 = 8'hC1;
	localparam logic [BYTE_W-1:0] TYPE_C3 = 8'hC3;
	localparam logic [BYTE_W-1:0] TYPE_C2 = 8'hC2;
	localparam logic [BYTE_W-1:0] TYPE_C4 = 8'hC4;

	localparam logic [KIND_W-1:0] KIND_C1 = 2'd0;
	localparam logic [KIND_W-1:0] KIND_C3 = 2'd1;
	localparam logic [KIND_W-1:0] KIND_C2 = 2'd2;
	localparam logic [KIND_W-1:0] KIND_C4 = 2'd3;

	localparam logic [LEN_W-1:0] HDR_SHORT = 16'd3;
	localparam logic [LEN_W-1:0] HDR_LONG  = 16'd4;

	localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd8192;

	typedef struct packed {
		logic [PH_W-1:0]   phase;
		logic [KIND_W-1:0] kind;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  off;
		logic [BYTE_W-1:0] code;
	} chst_t;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [BYTE_W-1:0] data;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] code;
		logic [LEN_W-1:0]  off;
		logic              first;
		logic              last;
		logic [ST_W-1:0]   status;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/core/mlpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlpd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/mlpd_step.sv
// Per-channel parse step: next channel state and the reported beat.
`default_nettype none
module mlpd_step (
	input  wire logic                         in_range,
	input  wire logic [mlpd_pkg::CH_W-1:0]    ch,
	input  wire logic [mlpd_pkg::BYTE_W-1:0]  data,
	input  wire logic [mlpd_pkg::LEN_W-1:0]   max_len,
	input  wire mlpd_pkg::chst_t              cur,
	output mlpd_pkg::chst_t                   nxt,
	output mlpd_pkg::res_t                    res
);

	logic [mlpd_pkg::LEN_W-1:0]  hdr;
	logic [mlpd_pkg::LEN_W-1:0]  off_inc;
	logic [mlpd_pkg::LEN_W-1:0]  len_full;
	logic                        end_hit;
	logic                        type_ok;
	logic [mlpd_pkg::KIND_W-1:0] type_kind;
	logic [mlpd_pkg::BYTE_W-1:0] code_now;

	always_comb begin
		type_ok   = 1'b1;
		type_kind = mlpd_pkg::KIND_C1;
		case (data)
			mlpd_pkg::TYPE_C1: type_kind = mlpd_pkg::KIND_C1;
			mlpd_pkg::TYPE_C3: type_kind = mlpd_pkg::KIND_C3;
			mlpd_pkg::TYPE_C2: type_kind = mlpd_pkg::KIND_C2;
			mlpd_pkg::TYPE_C4: type_kind = mlpd_pkg::KIND_C4;
			default:           type_ok   = 1'b0;
		endcase
	end

	assign hdr      = cur.kind[1] ? mlpd_pkg::HDR_LONG : mlpd_pkg::HDR_SHORT;
	assign off_inc  = cur.off + 16'd1;
	assign len_full = (cur.phase == mlpd_pkg::PH_LENLO) ? {cur.len[15:8], data}
		: {8'h00, data};
	assign end_hit  = ({1'b0, cur.off} + 17'd1) >= {1'b0, cur.len};
	assign code_now = (cur.phase == mlpd_pkg::PH_CODE) ? data : cur.code;

	always_comb begin
		nxt        = cur;
		res.ch     = ch;
		res.data   = data;
		res.kind   = '0;
		res.code   = '0;
		res.off    = '0;
		res.first  = 1'b0;
		res.last   = 1'b0;
		res.status = mlpd_pkg::ST_DISC;
		if (in_range) begin
			unique case (cur.phase) inside
				mlpd_pkg::PH_TYPE: begin
					if (type_ok) begin
						nxt.kind   = type_kind;
						nxt.code   = '0;
						nxt.len    = '0;
						nxt.off    = 16'd1;
						nxt.phase  = type_kind[1] ? mlpd_pkg::PH_LENHI : mlpd_pkg::PH_LEN1;
						res.kind   = type_kind;
						res.first  = 1'b1;
						res.status = mlpd_pkg::ST_OK;
					end else begin
						nxt.phase  = mlpd_pkg::PH_ERR;
						res.status = mlpd_pkg::ST_BADTYPE;
					end
				end
				mlpd_pkg::PH_LEN1, mlpd_pkg::PH_LENLO: begin
					nxt.len  = len_full;
					nxt.off  = off_inc;
					res.kind = cur.kind;
					res.off  = cur.off;
					if (len_full < hdr) begin
						nxt.phase  = mlpd_pkg::PH_ERR;
						res.status = mlpd_pkg::ST_SHORT;
					end else if (len_full > max_len) begin
						nxt.phase  = mlpd_pkg::PH_ERR;
						res.status = mlpd_pkg::ST_LONG;
					end else begin
						nxt.phase  = mlpd_pkg::PH_CODE;
						res.status = mlpd_pkg::ST_OK;
					end
				end
				mlpd_pkg::PH_LENHI: begin
					nxt.len    = {data, 8'h00};
					nxt.off    = off_inc;
					nxt.phase  = mlpd_pkg::PH_LENLO;
					res.kind   = cur.kind;
					res.off    = cur.off;
					res.status = mlpd_pkg::ST_OK;
				end
				mlpd_pkg::PH_CODE, mlpd_pkg::PH_BODY: begin
					nxt.code   = code_now;
					res.kind   = cur.kind;
					res.code   = code_now;
					res.off    = cur.off;
					res.last   = end_hit;
					res.status = mlpd_pkg::ST_OK;
					if (end_hit) begin
						nxt.phase = mlpd_pkg::PH_TYPE;
						nxt.off   = '0;
					end else begin
						nxt.phase = mlpd_pkg::PH_BODY;
						nxt.off   = off_inc;
					end
				end
				default: begin
					nxt.phase = mlpd_pkg::PH_ERR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/multichannel_length_prefixed_deframer.sv
// Top level of the multichannel length-prefixed deframer.
// Takes one byte per cycle while the output is not stalled, across any mix of
// channels; each accepted byte gives one output beat through the stage-one and
// output registers. Per-channel parse state lives in one RAM of CHANNELS
// entries: the read is issued as a byte is accepted, the updated state is
// written back as that byte leaves stage one, and a byte of the same channel
// right behind takes the written state from a forwarding register. One valid
// flop per entry stands in for the reset value, so no clearing pass runs after
// reset. Channels at or above CHANNELS report status discarded and touch no state.
`default_nettype none
module multichannel_length_prefixed_deframer #(
	parameter int unsigned CHANNELS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // channel[5:0], rx_byte[13:6]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // out_channel[5:0], data_byte[13:6],
	                                    // frame_code[21:14], byte_offset[37:22]
	output logic      [5:0]  m_tuser,   // frame_kind[1:0], first_byte[2], status[5:3]
	output logic             m_tlast,   // last_byte
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // max_frame_len
);

	localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned SW = $bits(mlpd_pkg::chst_t);

	logic [mlpd_pkg::CH_W-1:0]   s_ch;
	logic [mlpd_pkg::BYTE_W-1:0] s_byte;
	logic                        accept;
	logic                        adv_s1;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               raddr;
	logic [SW-1:0]               rdata;

	logic [mlpd_pkg::LEN_W-1:0]  max_len_q;
	logic [CHANNELS-1:0]         vld_q;

	logic                        v_s1;
	logic [mlpd_pkg::CH_W-1:0]   ch_s1;
	logic [mlpd_pkg::BYTE_W-1:0] byte_s1;
	logic                        rng_s1;
	logic                        vld_s1;
	logic                        byp_hit_s1;
	mlpd_pkg::chst_t             byp_st_s1;

	mlpd_pkg::chst_t             cur;
	mlpd_pkg::chst_t             nxt;
	mlpd_pkg::res_t              res;

	logic                        m_v_q;
	mlpd_pkg::res_t              m_res_q;

	assign s_ch   = s_tdata[5:0];
	assign s_byte = s_tdata[13:6];

	assign adv_s1   = v_s1 && (!m_v_q || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	assign we    = adv_s1 && rng_s1;
	assign waddr = AW'(ch_s1);
	assign raddr = AW'(s_ch);

	mlpd_ram #(
		.WIDTH (SW),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (nxt),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (byp_hit_s1) begin
			cur = byp_st_s1;
		end else if (vld_s1) begin
			cur = mlpd_pkg::chst_t'(rdata);
		end else begin
			cur = '0;
		end
	end

	mlpd_step u_step (
		.in_range (rng_s1),
		.ch       (ch_s1),
		.data     (byte_s1),
		.max_len  (max_len_q),
		.cur      (cur),
		.nxt      (nxt),
		.res      (res)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= mlpd_pkg::MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			byp_hit_s1 <= 1'b0;
			vld_s1     <= 1'b0;
			rng_s1     <= 1'b0;
		end else begin
			if (accept) begin
				v_s1       <= 1'b1;
				byp_hit_s1 <= we && (ch_s1 == s_ch);
				vld_s1     <= (11'(s_ch) < 11'(CHANNELS)) ? vld_q[raddr] : 1'b0;
				rng_s1     <= 11'(s_ch) < 11'(CHANNELS);
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1     <= s_ch;
			byte_s1   <= s_byte;
			byp_st_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
		end else if (adv_s1) begin
			m_v_q <= 1'b1;
		end else if (m_tready) begin
			m_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_v_q;
	assign m_tdata  = {2'b00, m_res_q.off, m_res_q.code, m_res_q.data, m_res_q.ch};
	assign m_tuser  = {m_res_q.status, m_res_q.first, m_res_q.kind};
	assign m_tlast  = m_res_q.last;

endmodule
`default_nettype wire

>>> rtl/core/mlpd_chk.sv
// Port-level checker for the deframer, bound to the top level.
`default_nettype none
`include "multichannel_length_prefixed_deframer_defines.svh"
module mlpd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [5:0]  m_tuser,
	input wire logic        m_tlast
);

	`MLPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`MLPD_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid)
	`MLPD_ASSERT_NOW(a_first_clean, m_tvalid && m_tuser[2],
		m_tuser[5:3] == mlpd_pkg::ST_OK && m_tdata[37:22] == 16'd0 && !m_tlast)
	`MLPD_ASSERT_NOW(a_error_zeroed,
		m_tvalid && (m_tuser[5:3] == mlpd_pkg::ST_BADTYPE || m_tuser[5:3] == mlpd_pkg::ST_DISC),
		m_tdata[37:22] == 16'd0 && m_tdata[21:14] == 8'd0 && !m_tlast && !m_tuser[2])
	`MLPD_ASSERT_NOW(a_last_ok, m_tvalid && m_tlast, m_tuser[5:3] == mlpd_pkg::ST_OK)

endmodule

bind multichannel_length_prefixed_deframer mlpd_chk u_mlpd_chk (.*);
`default_nettype wire
